>>> src/assert_macros.svh
// assertion macros shared by the stack_with_positional_edit rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SWPE_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("swpe assertion failed");
`define SWPE_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("swpe assertion failed");
`else
`define SWPE_ASSERT(label, clk, rst, prop)
`define SWPE_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> src/swpe_pkg.sv
// types and constants for the stack_with_positional_edit block
// no dependencies; used by the interfaces, controller, datapath and top level
`timescale 1ns / 1ps

package swpe_pkg;

  localparam int OP_W     = 3;
  localparam int WORD_W   = 64;
  localparam int POS_W    = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;
  localparam int ACT_W    = 3;

  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

  localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd4;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd5;

  typedef struct packed {
    logic                capture;
    logic                execute;
    logic [ACT_W-1:0]    act;
    logic [STATUS_W-1:0] status;
  } swpe_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
    logic            pos_pos;
    logic            del_top;
    logic            read_ok;
  } swpe_flags_t;

endpackage

>>> src/swpe_in_if.sv
// request channel of the stack_with_positional_edit block
// depends on swpe_pkg
`timescale 1ns / 1ps

interface swpe_in_if;
  import swpe_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [WORD_W-1:0]       value;
  logic signed [POS_W-1:0] position;

  modport source (output valid, output op, output value, output position, input ready);
  modport sink (input valid, input op, input value, input position, output ready);
endinterface

>>> src/swpe_out_if.sv
// response channel of the stack_with_positional_edit block
// depends on swpe_pkg
`timescale 1ns / 1ps

interface swpe_out_if;
  import swpe_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0]    occupancy;
  logic [WORD_W-1:0]   top_word;
  logic [WORD_W-1:0]   read_word;

  modport source (output valid, output status, output occupancy, output top_word,
                  output read_word, input ready);
  modport sink (input valid, input status, input occupancy, input top_word,
                input read_word, output ready);
endinterface

>>> src/swpe_ctrl.sv
// controller: request handshake, operation decode and response valid
// depends on swpe_pkg; drives the datapath through swpe_cmd_t
`timescale 1ns / 1ps

module swpe_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  rsp_ready,
  input  swpe_pkg::swpe_flags_t flags,
  output logic                  req_ready,
  output logic                  rsp_valid,
  output swpe_pkg::swpe_cmd_t   cmd
);
  import swpe_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid;
  logic out_valid_next;

  assign req_ready = (state == S_IDLE) && (!out_valid || rsp_ready);
  assign rsp_valid = out_valid;

  always_comb begin
    cmd         = '0;
    cmd.capture = req_valid && req_ready;
    cmd.execute = (state == S_EXEC);
    cmd.act     = ACT_NONE;
    cmd.status  = ST_OK;
    case (flags.op)
      OP_PUSH: begin
        if (flags.full) cmd.status = ST_FULL;
        else cmd.act = ACT_PUSH;
      end
      OP_POP: begin
        if (flags.empty) cmd.status = ST_EMPTY;
        else cmd.act = ACT_POP;
      end
      OP_INSERT: begin
        if (flags.empty || !flags.pos_pos) cmd.status = ST_INVALID;
        else if (flags.full) cmd.status = ST_FULL;
        else cmd.act = ACT_INSERT;
      end
      OP_DELETE: begin
        if (flags.empty || !flags.pos_pos || flags.del_top) cmd.status = ST_INVALID;
        else cmd.act = ACT_DELETE;
      end
      OP_READ: begin
        if (!flags.read_ok) cmd.status = ST_INVALID;
        else cmd.act = ACT_READ;
      end
      default: begin
        cmd.status = ST_INVALID;
      end
    endcase
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    case (state)
      S_IDLE: begin
        if (cmd.capture) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (cmd.execute) out_valid_next = 1'b1;
    else if (out_valid && rsp_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end
endmodule

>>> src/swpe_dp.sv
// datapath: request register, shifting entry array, count and response register
// depends on swpe_pkg and assert_macros.svh; commanded by swpe_ctrl
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swpe_dp #(
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  swpe_pkg::swpe_cmd_t                   cmd,
  input  logic [swpe_pkg::OP_W-1:0]             req_op,
  input  logic [swpe_pkg::WORD_W-1:0]           req_value,
  input  logic signed [swpe_pkg::POS_W-1:0]     req_position,
  output swpe_pkg::swpe_flags_t                 flags,
  output logic [swpe_pkg::STATUS_W-1:0]         rsp_status,
  output logic [swpe_pkg::OCC_W-1:0]            rsp_occupancy,
  output logic [swpe_pkg::WORD_W-1:0]           rsp_top_word,
  output logic [swpe_pkg::WORD_W-1:0]           rsp_read_word
);
  import swpe_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  logic [OP_W-1:0]         op_q;
  logic [WORD_W-1:0]       value_q;
  logic signed [POS_W-1:0] pos_q;

  logic [WORD_W-1:0] entries [DEPTH];
  logic [WORD_W-1:0] entries_next [DEPTH];
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  logic [POS_W-1:0]  posu;
  logic [POS_W-1:0]  cnt16;
  logic [POS_W-1:0]  cnt16_m1;
  logic [POS_W-1:0]  ins_k16;
  logic [POS_W-1:0]  del_k16;
  logic [IDX_W-1:0]  k;
  logic              do_ins;
  logic              do_del;
  logic [WORD_W-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= req_op;
      value_q <= req_value;
      pos_q   <= req_position;
    end
  end

  assign posu     = pos_q;
  assign cnt16    = POS_W'(count);
  assign cnt16_m1 = cnt16 - POS_W'(1);

  assign flags.op      = op_q;
  assign flags.empty   = (count == '0);
  assign flags.full    = (count == CNT_MAX);
  assign flags.pos_pos = !pos_q[POS_W-1] && (pos_q != '0);
  assign flags.del_top = (count == CNT_W'(1));
  assign flags.read_ok = !pos_q[POS_W-1] && (posu < cnt16);

  assign ins_k16 = (posu < cnt16) ? posu : cnt16;
  assign del_k16 = (posu < cnt16_m1) ? posu : cnt16_m1;
  assign do_ins  = (cmd.act == ACT_PUSH) || (cmd.act == ACT_INSERT);
  assign do_del  = (cmd.act == ACT_POP) || (cmd.act == ACT_DELETE);

  always_comb begin
    case (cmd.act)
      ACT_INSERT: k = IDX_W'(ins_k16);
      ACT_DELETE: k = IDX_W'(del_k16);
      default:    k = '0;
    endcase
  end

  // each entry takes its own value, the new word, or a neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_entry
    localparam logic [IDX_W-1:0] I = IDX_W'(i);
    logic [WORD_W-1:0] below;
    logic [WORD_W-1:0] above;
    if (i == 0) begin : g_first
      assign above = value_q;
    end else begin : g_mid_a
      assign above = entries[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign below = entries[i];
    end else begin : g_mid_b
      assign below = entries[i+1];
    end
    always_comb begin
      entries_next[i] = entries[i];
      if (do_ins) begin
        if (I == k) entries_next[i] = value_q;
        else if (I > k) entries_next[i] = above;
      end else if (do_del) begin
        if (I >= k) entries_next[i] = below;
      end
    end
    always_ff @(posedge clk) begin
      if (cmd.execute) entries[i] <= entries_next[i];
    end
  end

  always_comb begin
    count_next = count;
    if (do_ins) count_next = count + CNT_W'(1);
    else if (do_del) count_next = count - CNT_W'(1);
  end

  assign rd_word = (cmd.act == ACT_READ) ? entries[IDX_W'(posu)] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.execute) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      rsp_status    <= cmd.status;
      rsp_occupancy <= OCC_W'(count_next);
      rsp_top_word  <= (count_next != '0) ? entries_next[0] : '0;
      rsp_read_word <= rd_word;
    end
  end

  `SWPE_ASSERT(a_count_bound, clk, rst, count <= CNT_MAX)
  `SWPE_ASSERT(a_push_grows, clk, rst, cmd.execute && cmd.act == ACT_PUSH |=> count == $past(count) + CNT_W'(1))
  `SWPE_ASSERT(a_read_keeps, clk, rst, cmd.execute && cmd.act == ACT_READ |=> $stable(count))
endmodule

>>> src/stack_with_positional_edit.sv
// Bounded stack of 64-bit words (entry 0 is the top) with push, pop, insert
// at a position, delete at a position and indexed read.
// Channels: req (sink) carries op, value and position; rsp (source) carries
// status, occupancy, top_word and read_word. A transfer takes place on a
// rising clk edge with valid and ready both high; every request yields
// exactly one response.
// The request is registered on the accepting edge; on the next edge the entry
// array shifts in parallel and the response is registered and made valid.
// A new request is not taken until the controller has gone through its
// capture and execute steps.
// A new request is taken while the previous response is still held, as
// long as that response is taken in the same cycle; while the receiver
// stalls, the response holds and req.ready stays low.
// Reset (rst, synchronous, active high) empties the stack and drops any
// pending response; no clearing pass is needed.
// Depends on swpe_pkg, swpe_in_if, swpe_out_if, swpe_ctrl and swpe_dp.
`timescale 1ns / 1ps

module stack_with_positional_edit #(
  parameter int DEPTH = 16
) (
  input logic        clk,
  input logic        rst,
  swpe_in_if.sink    req,
  swpe_out_if.source rsp
);
  import swpe_pkg::*;

  swpe_cmd_t   cmd;
  swpe_flags_t flags;

  swpe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .rsp_ready (rsp.ready),
    .flags     (flags),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .cmd       (cmd)
  );

  swpe_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req_op        (req.op),
    .req_value     (req.value),
    .req_position  (req.position),
    .flags         (flags),
    .rsp_status    (rsp.status),
    .rsp_occupancy (rsp.occupancy),
    .rsp_top_word  (rsp.top_word),
    .rsp_read_word (rsp.read_word)
  );
endmodule

>>> test/stack_with_positional_edit_test.sv
// testbench for the stack_with_positional_edit block: directed and random requests,
// random idling on both channels, responses checked against an in-bench stack model
// depends on swpe_pkg, swpe_in_if, swpe_out_if and stack_with_positional_edit
`timescale 1ns / 1ps

import swpe_pkg::*;

typedef struct {
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0]    occupancy;
  logic [WORD_W-1:0]   top_word;
  logic [WORD_W-1:0]   read_word;
} stack_response_t;

class stack_scoreboard;
  localparam int DEPTH = 16;

  logic [WORD_W-1:0] words [DEPTH];
  int                held;
  stack_response_t   pending[$];
  int                mismatches;

  function new();
    held = 0;
    mismatches = 0;
  endfunction

  // open a slot at index k
  function void shift_down(int k);
    for (int i = held; i > k; i--) words[i] = words[i - 1];
  endfunction

  // close the slot at index k
  function void shift_up(int k);
    for (int i = k; i + 1 < held; i++) words[i] = words[i + 1];
  endfunction

  function void note_request(logic [OP_W-1:0] op, logic [WORD_W-1:0] value,
                             logic signed [POS_W-1:0] position);
    stack_response_t e;
    int pos;
    int k;
    pos = position;
    e.status = ST_OK;
    e.read_word = '0;
    case (op)
      OP_PUSH: begin
        if (held >= DEPTH) e.status = ST_FULL;
        else begin
          shift_down(0);
          words[0] = value;
          held++;
        end
      end
      OP_POP: begin
        if (held == 0) e.status = ST_EMPTY;
        else begin
          shift_up(0);
          held--;
        end
      end
      OP_INSERT: begin
        if (held == 0 || pos <= 0) e.status = ST_INVALID;
        else if (held >= DEPTH) e.status = ST_FULL;
        else begin
          k = (pos < held) ? pos : held;
          shift_down(k);
          words[k] = value;
          held++;
        end
      end
      OP_DELETE: begin
        if (held == 0 || pos <= 0) e.status = ST_INVALID;
        else begin
          k = (pos < held - 1) ? pos : held - 1;
          if (k == 0) e.status = ST_INVALID;
          else begin
            shift_up(k);
            held--;
          end
        end
      end
      OP_READ: begin
        if (pos < 0 || pos >= held) e.status = ST_INVALID;
        else e.read_word = words[pos];
      end
      default: begin
        e.status = ST_INVALID;
      end
    endcase
    e.occupancy = OCC_W'(held);
    e.top_word = (held > 0) ? words[0] : '0;
    pending.push_back(e);
  endfunction

  function void check_response(logic [STATUS_W-1:0] status, logic [OCC_W-1:0] occupancy,
                               logic [WORD_W-1:0] top_word, logic [WORD_W-1:0] read_word);
    stack_response_t e;
    if (pending.size() == 0) begin
      $error("response with no request outstanding");
      mismatches++;
      return;
    end
    e = pending.pop_front();
    if (status !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, status);
      mismatches++;
    end
    if (occupancy !== e.occupancy) begin
      $error("occupancy: expected %0d, got %0d", e.occupancy, occupancy);
      mismatches++;
    end
    if (top_word !== e.top_word) begin
      $error("top_word: expected %h, got %h", e.top_word, top_word);
      mismatches++;
    end
    if (read_word !== e.read_word) begin
      $error("read_word: expected %h, got %h", e.read_word, read_word);
      mismatches++;
    end
  endfunction
endclass

module stack_with_positional_edit_test;
  localparam int STACK_DEPTH  = 16;
  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_NOISE} traffic_mode_t;

  logic clk;
  logic rst;
  bit   no_idle;
  int   cycle_count;

  stack_scoreboard board = new();

  swpe_in_if  req_if ();
  swpe_out_if rsp_if ();

  stack_with_positional_edit #(.DEPTH(STACK_DEPTH)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mostly short gaps, a few long ones
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [POS_W-1:0] pick_position(traffic_mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == MODE_NOISE || r >= 92) return POS_W'($urandom);
    if (r < 84) return POS_W'(int'($urandom_range(0, STACK_DEPTH + 2)) - 1);
    case ($urandom_range(0, 3))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op(traffic_mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (r < 55) return OP_PUSH;
        if (r < 80) return OP_INSERT;
        if (r < 90) return OP_READ;
        if (r < 95) return OP_POP;
        return OP_DELETE;
      end
      MODE_DRAIN: begin
        if (r < 45) return OP_POP;
        if (r < 75) return OP_DELETE;
        if (r < 85) return OP_READ;
        if (r < 95) return OP_PUSH;
        return OP_INSERT;
      end
      MODE_MIXED: return OP_W'($urandom_range(OP_PUSH, OP_READ));
      default: return OP_W'($urandom);
    endcase
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] value,
                              input logic signed [POS_W-1:0] position);
    int gap;
    gap = no_idle ? 0 : idle_cycles();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.op       <= op;
    req_if.value    <= value;
    req_if.position <= position;
    do @(posedge clk); while (!req_if.ready);
    board.note_request(op, value, position);
  endtask

  task automatic drain_responses();
    req_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** stack_with_positional_edit: FAILED **");
    $finish;
  end

  initial begin : response_side
    int stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready)
        board.check_response(rsp_if.status, rsp_if.occupancy, rsp_if.top_word,
                             rsp_if.read_word);
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) stall_left = idle_cycles();
      end
    end
  end

  initial begin : request_side
    traffic_mode_t mode;
    int            sent;
    int            seg_len;
    rst             <= 1'b1;
    no_idle         = 1'b0;
    req_if.valid    <= 1'b0;
    req_if.op       <= OP_PUSH;
    req_if.value    <= '0;
    req_if.position <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty stack
    send_request(OP_POP, 64'h1, 16'sd0);
    send_request(OP_INSERT, 64'h2, 16'sd1);
    send_request(OP_DELETE, '0, 16'sd1);
    send_request(OP_READ, '0, 16'sd0);
    // single entry: delete clamps onto the top
    send_request(OP_PUSH, '0, 16'sd0);
    send_request(OP_DELETE, '0, 16'sd1);
    send_request(OP_PUSH, '1, 16'sd0);
    // bad insert positions, then append past the end and insert in the middle
    send_request(OP_INSERT, 64'hdead_beef_0000_0001, 16'sd0);
    send_request(OP_INSERT, 64'hdead_beef_0000_0002, 16'sh8000);
    send_request(OP_INSERT, 64'ha5a5_a5a5_a5a5_a5a5, 16'sh7fff);
    send_request(OP_INSERT, 64'h0123_4567_89ab_cdef, 16'sd1);
    // reads in and out of range
    send_request(OP_READ, '0, 16'sd3);
    send_request(OP_READ, '0, 16'sd1);
    send_request(OP_READ, '0, 16'shffff);
    send_request(OP_READ, '0, 16'sh7fff);
    send_request(OP_READ, '0, 16'sd4);
    // bad delete positions, middle delete, delete past the end
    send_request(OP_DELETE, '0, 16'sd0);
    send_request(OP_DELETE, '0, 16'sh8000);
    send_request(OP_DELETE, '0, 16'sd1);
    send_request(OP_DELETE, '0, 16'sh7fff);
    // unused op codes
    for (int c = OP_READ + 1; c < 2 ** OP_W; c++)
      send_request(OP_W'(c), '1, 16'shffff);
    drain_responses();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 99) / 10)
        0, 1, 2: mode = MODE_FILL;
        3, 4, 5: mode = MODE_DRAIN;
        6, 7:    mode = MODE_MIXED;
        default: mode = MODE_NOISE;
      endcase
      no_idle = ($urandom_range(0, 4) == 0);
      seg_len = $urandom_range(20, 80);
      for (int i = 0; i < seg_len; i++) begin
        send_request(pick_op(mode), pick_word(), pick_position(mode));
        sent++;
      end
      if ($urandom_range(0, 5) == 0) drain_responses();
    end

    no_idle = 1'b0;
    drain_responses();
    repeat (10) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("** stack_with_positional_edit: PASSED **");
    end else begin
      $display("** stack_with_positional_edit: FAILED **");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+src
src/swpe_pkg.sv
src/swpe_in_if.sv
src/swpe_out_if.sv
src/swpe_ctrl.sv
src/swpe_dp.sv
src/stack_with_positional_edit.sv
test/stack_with_positional_edit_test.sv
